// ===== hw/rtl/c_subset_token_lexer_unit_assert.svh =====
// Assertion helpers for the lexer RTL (included by cstl_queue).
`ifndef C_SUBSET_TOKEN_LEXER_UNIT_ASSERT_SVH
`define C_SUBSET_TOKEN_LEXER_UNIT_ASSERT_SVH

// cond must never hold outside reset
`define CSTL_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("never violated");

// when trig holds, chk must hold in the next cycle
`define CSTL_ASSERT_NEXT(label, clk, rstn, trig, chk) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (chk)) \
        else $error("next-cycle check violated");

`endif

// ===== hw/rtl/cstl_pkg.sv =====
package cstl_pkg;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_SLASH = 4'd1,
        M_LINE  = 4'd2,
        M_BLOCK = 4'd3,
        M_BSTAR = 4'd4,
        M_IDENT = 4'd5,
        M_ZERO  = 4'd6,
        M_DEC   = 4'd7,
        M_OCT   = 4'd8,
        M_ODEAD = 4'd9,
        M_HEX   = 4'd10,
        M_OP    = 4'd11,
        M_HALT  = 4'd12
    } mode_t;

    localparam logic [5:0] K_INT     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_KW      = 6'd2;
    localparam logic [5:0] K_PLUS    = 6'd8;
    localparam logic [5:0] K_ARROW   = 6'd9;
    localparam logic [5:0] K_MINUS   = 6'd10;
    localparam logic [5:0] K_STAR    = 6'd11;
    localparam logic [5:0] K_SLASH   = 6'd12;
    localparam logic [5:0] K_LAND    = 6'd13;
    localparam logic [5:0] K_AMP     = 6'd14;
    localparam logic [5:0] K_LOR     = 6'd15;
    localparam logic [5:0] K_PIPE    = 6'd16;
    localparam logic [5:0] K_CARET   = 6'd17;
    localparam logic [5:0] K_TILDE   = 6'd18;
    localparam logic [5:0] K_SHL     = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_LT      = 6'd21;
    localparam logic [5:0] K_SHR     = 6'd22;
    localparam logic [5:0] K_GE      = 6'd23;
    localparam logic [5:0] K_GT      = 6'd24;
    localparam logic [5:0] K_EQ      = 6'd25;
    localparam logic [5:0] K_ASSIGN  = 6'd26;
    localparam logic [5:0] K_NE      = 6'd27;
    localparam logic [5:0] K_NOT     = 6'd28;
    localparam logic [5:0] K_LPAREN  = 6'd29;
    localparam logic [5:0] K_RPAREN  = 6'd30;
    localparam logic [5:0] K_LBRACE  = 6'd31;
    localparam logic [5:0] K_RBRACE  = 6'd32;
    localparam logic [5:0] K_LBRACK  = 6'd33;
    localparam logic [5:0] K_RBRACK  = 6'd34;
    localparam logic [5:0] K_SEMI    = 6'd35;
    localparam logic [5:0] K_COMMA   = 6'd36;
    localparam logic [5:0] K_END     = 6'd37;
    localparam logic [5:0] K_ERR     = 6'd38;

    localparam int          NUM_KW   = 6;
    localparam logic [62:0] VMAX     = {63{1'b1}};
    localparam int          QDEPTH   = 4;

    typedef struct packed {
        logic [5:0]  kind;
        logic [62:0] value;
        logic [15:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic        last;
    } tok_t;

    typedef struct packed {
        tok_t tok0;
        tok_t tok1;
        logic two;
    } step_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [47:0] s;
        begin
            case (k)
                3'd0:    s = "int";
                3'd1:    s = "if";
                3'd2:    s = "else";
                3'd3:    s = "while";
                3'd4:    s = "for";
                3'd5:    s = "return";
                default: s = '0;
            endcase
            // string literals are right aligned; keyword length picks the first char
            case (k)
                3'd0:    kw_char = (p < 3'd3) ? s[8*(2-p) +: 8] : 8'd0;
                3'd1:    kw_char = (p < 3'd2) ? s[8*(1-p) +: 8] : 8'd0;
                3'd2:    kw_char = (p < 3'd4) ? s[8*(3-p) +: 8] : 8'd0;
                3'd3:    kw_char = (p < 3'd5) ? s[8*(4-p) +: 8] : 8'd0;
                3'd4:    kw_char = (p < 3'd3) ? s[8*(2-p) +: 8] : 8'd0;
                3'd5:    kw_char = (p < 3'd6) ? s[8*(5-p) +: 8] : 8'd0;
                default: kw_char = 8'd0;
            endcase
        end
    endfunction

    function automatic logic [15:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0:    kw_len = 16'd3;
            3'd1:    kw_len = 16'd2;
            3'd2:    kw_len = 16'd4;
            3'd3:    kw_len = 16'd5;
            3'd4:    kw_len = 16'd3;
            3'd5:    kw_len = 16'd6;
            default: kw_len = 16'd0;
        endcase
    endfunction

    function automatic logic [5:0] kw_match(input logic [5:0] m, input logic [15:0] p,
                                            input logic [7:0] c);
        logic [5:0] r;
        begin
            r = m;
            for (int k = 0; k < NUM_KW; k++) begin
                if (p >= 16'd8 || kw_char(3'(k), p[2:0]) != c) begin
                    r[k] = 1'b0;
                end
            end
            kw_match = r;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (is_digit(c)) begin
            hex_val = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            hex_val = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            hex_val = {1'b1, 4'(c - "A" + 8'd10)};
        end else begin
            hex_val = 5'd0;
        end
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] p);
        case (p)
            "-":     single_kind = K_MINUS;
            "&":     single_kind = K_AMP;
            "|":     single_kind = K_PIPE;
            "<":     single_kind = K_LT;
            ">":     single_kind = K_GT;
            "=":     single_kind = K_ASSIGN;
            default: single_kind = K_NOT;
        endcase
    endfunction

    // {valid, kind}
    function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        pair_kind = 7'd0;
        case (p)
            "-": if (c == ">") pair_kind = {1'b1, K_ARROW};
            "&": if (c == "&") pair_kind = {1'b1, K_LAND};
            "|": if (c == "|") pair_kind = {1'b1, K_LOR};
            "<": begin
                if (c == "<") pair_kind = {1'b1, K_SHL};
                else if (c == "=") pair_kind = {1'b1, K_LE};
            end
            ">": begin
                if (c == ">") pair_kind = {1'b1, K_SHR};
                else if (c == "=") pair_kind = {1'b1, K_GE};
            end
            "=": if (c == "=") pair_kind = {1'b1, K_EQ};
            "!": if (c == "=") pair_kind = {1'b1, K_NE};
            default: pair_kind = 7'd0;
        endcase
    endfunction

    // {valid, kind} for a self-contained single-character token
    function automatic logic [6:0] punct_kind(input logic [7:0] c);
        case (c)
            "+":     punct_kind = {1'b1, K_PLUS};
            "*":     punct_kind = {1'b1, K_STAR};
            "^":     punct_kind = {1'b1, K_CARET};
            "~":     punct_kind = {1'b1, K_TILDE};
            "(":     punct_kind = {1'b1, K_LPAREN};
            ")":     punct_kind = {1'b1, K_RPAREN};
            "{":     punct_kind = {1'b1, K_LBRACE};
            "}":     punct_kind = {1'b1, K_RBRACE};
            "[":     punct_kind = {1'b1, K_LBRACK};
            "]":     punct_kind = {1'b1, K_RBRACK};
            ";":     punct_kind = {1'b1, K_SEMI};
            ",":     punct_kind = {1'b1, K_COMMA};
            default: punct_kind = 7'd0;
        endcase
    endfunction

    function automatic logic is_op_lead(input logic [7:0] c);
        is_op_lead = (c == "-") || (c == "&") || (c == "|") || (c == "<") ||
                     (c == ">") || (c == "=") || (c == "!");
    endfunction

endpackage

// ===== hw/rtl/c_subset_token_lexer_unit.sv =====
// A taken byte's tokens are written into the queue; the back end then loads them one at
// a time into its output registers, which drive m_tvalid, m_tdata, m_tuser and m_tlast.
// One byte per cycle while s_tready is high; s_tready drops while the 4-entry queue is
// full. Each entry holds the one or two tokens of a byte that yields any.
// Reset: aresetn synchronous, active low; position line 1, column 1, offset 0.
// An end marker also returns the lexer to its reset state after emitting END.
module c_subset_token_lexer_unit #(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_byte
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // int_value, start_line, start_column, start_offset,
                                    // token_length, zero pad
    output logic [5:0]   m_tuser,   // token_kind
    output logic         m_tlast    // last_of_run
);

    logic              in_fire;
    logic              push, pop;
    cstl_pkg::step_t   push_data, head;
    cstl_pkg::q_stat_t stat;
    cstl_pkg::tok_t    out_tok;

    assign s_tready = !stat.full;
    assign in_fire  = s_tvalid && s_tready;

    cstl_front #(
        .LINE_WIDTH  (LINE_WIDTH),
        .COLUMN_WIDTH(COLUMN_WIDTH),
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_char  (s_tdata),
        .in_end   (s_tlast),
        .push     (push),
        .push_data(push_data)
    );

    cstl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    cstl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_tok  (out_tok)
    );

    assign m_tdata = {1'b0, out_tok.length, out_tok.offset, out_tok.column,
                      out_tok.line, out_tok.value};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last;

endmodule

// ===== hw/rtl/cstl_front.sv =====
module cstl_front #(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_char,
    input  logic            in_end,
    output logic            push,
    output cstl_pkg::step_t push_data
);

    cstl_pkg::mode_t mode_reg, mode_next;
    logic [5:0]              kw_reg, kw_next;
    logic [62:0]             acc_reg, acc_next;
    logic                    sat_reg, sat_next;
    logic [7:0]              op_reg, op_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next, tsl_reg, tsl_next;
    logic [COLUMN_WIDTH-1:0] col_reg, col_next, tsc_reg, tsc_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next, tso_reg, tso_next;
    logic [15:0]             cnt_reg, cnt_next;

    logic [7:0]  c;
    logic        fl_valid;
    cstl_pkg::tok_t fl_tok;
    logic        a_valid, b_valid;
    cstl_pkg::tok_t a_tok, b_tok;
    logic [6:0]  pk, pu;
    logic [4:0]  hv;
    logic        do_fresh;
    logic        add_en;
    logic [1:0]  add_base;
    logic [3:0]  add_digit;
    logic [66:0] add_sum;
    logic [62:0] acc_add;
    logic        sat_add;
    logic [15:0] cnt_inc;

    assign c       = in_char;
    assign pk      = cstl_pkg::pair_kind(op_reg, c);
    assign pu      = cstl_pkg::punct_kind(c);
    assign hv      = cstl_pkg::hex_val(c);
    assign cnt_inc = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    // base: 0 octal, 1 decimal, 2 hex
    always_comb begin
        case (add_base)
            2'd0:    add_sum = {1'b0, acc_reg, 3'b0} + 67'(add_digit);
            2'd1:    add_sum = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + 67'(add_digit);
            default: add_sum = {acc_reg, 4'b0} + 67'(add_digit);
        endcase
        if (sat_reg) begin
            acc_add = acc_reg;
            sat_add = 1'b1;
        end else if (add_sum[66:63] != 4'd0) begin
            acc_add = cstl_pkg::VMAX;
            sat_add = 1'b1;
        end else begin
            acc_add = add_sum[62:0];
            sat_add = 1'b0;
        end
    end

    // token held in the current mode
    always_comb begin
        fl_tok        = '0;
        fl_tok.line   = 16'(tsl_reg);
        fl_tok.column = 16'(tsc_reg);
        fl_tok.offset = 32'(tso_reg);
        fl_tok.length = cnt_reg;
        fl_valid      = 1'b1;
        case (mode_reg)
            cstl_pkg::M_IDENT: begin
                fl_tok.kind = cstl_pkg::K_IDENT;
                for (int k = 0; k < cstl_pkg::NUM_KW; k++) begin
                    if (kw_reg[k] && cstl_pkg::kw_len(3'(k)) == cnt_reg) begin
                        fl_tok.kind = cstl_pkg::K_KW + 6'(k);
                    end
                end
            end
            cstl_pkg::M_ZERO, cstl_pkg::M_DEC, cstl_pkg::M_OCT,
            cstl_pkg::M_ODEAD, cstl_pkg::M_HEX: begin
                fl_tok.kind  = cstl_pkg::K_INT;
                fl_tok.value = acc_reg;
            end
            cstl_pkg::M_OP: begin
                fl_tok.kind   = cstl_pkg::single_kind(op_reg);
                fl_tok.length = 16'd1;
            end
            cstl_pkg::M_SLASH: begin
                fl_tok.kind   = cstl_pkg::K_SLASH;
                fl_tok.length = 16'd1;
            end
            default: fl_valid = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        do_fresh  = 1'b0;
        mode_next = mode_reg;
        kw_next   = kw_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        op_next   = op_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        tso_next  = tso_reg;
        cnt_next  = cnt_reg;
        add_en    = 1'b0;
        add_base  = 2'd1;
        add_digit = 4'(c - "0");

        // position update
        if (c == 8'h0A) begin
            line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
            col_next  = COLUMN_WIDTH'(1);
        end else begin
            line_next = line_reg;
            col_next  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
        end
        off_next = (off_reg == '1) ? off_reg : off_reg + 1'b1;

        if (in_end) begin
            mode_next = cstl_pkg::M_IDLE;
            kw_next   = '0;
            acc_next  = '0;
            sat_next  = 1'b0;
            op_next   = '0;
            line_next = LINE_WIDTH'(1);
            col_next  = COLUMN_WIDTH'(1);
            off_next  = '0;
            tsl_next  = LINE_WIDTH'(1);
            tsc_next  = COLUMN_WIDTH'(1);
            tso_next  = '0;
            cnt_next  = '0;
        end else begin
            case (mode_reg)
                cstl_pkg::M_HALT: ;
                cstl_pkg::M_LINE: if (c == 8'h0A) mode_next = cstl_pkg::M_IDLE;
                cstl_pkg::M_BLOCK: if (c == "*") mode_next = cstl_pkg::M_BSTAR;
                cstl_pkg::M_BSTAR: begin
                    if (c == "/") mode_next = cstl_pkg::M_IDLE;
                    else if (c != "*") mode_next = cstl_pkg::M_BLOCK;
                end
                cstl_pkg::M_SLASH: begin
                    if (c == "/") mode_next = cstl_pkg::M_LINE;
                    else if (c == "*") mode_next = cstl_pkg::M_BLOCK;
                    else do_fresh = 1'b1;
                end
                cstl_pkg::M_OP: begin
                    if (pk[6]) begin
                        mode_next = cstl_pkg::M_IDLE;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                cstl_pkg::M_IDENT: begin
                    if (cstl_pkg::is_alpha(c) || cstl_pkg::is_digit(c) || c == "_") begin
                        kw_next  = cstl_pkg::kw_match(kw_reg, cnt_reg, c);
                        cnt_next = cnt_inc;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                cstl_pkg::M_ZERO: begin
                    if (c == "x" || c == "X") begin
                        cnt_next  = cnt_inc;
                        mode_next = cstl_pkg::M_HEX;
                    end else if (cstl_pkg::is_digit(c)) begin
                        cnt_next = cnt_inc;
                        if (c < "8") begin
                            add_en    = 1'b1;
                            add_base  = 2'd0;
                            mode_next = cstl_pkg::M_OCT;
                        end else begin
                            mode_next = cstl_pkg::M_ODEAD;
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                cstl_pkg::M_DEC, cstl_pkg::M_OCT, cstl_pkg::M_ODEAD: begin
                    if (cstl_pkg::is_digit(c)) begin
                        cnt_next = cnt_inc;
                        if (mode_reg == cstl_pkg::M_DEC) begin
                            add_en = 1'b1;
                        end else if (mode_reg == cstl_pkg::M_OCT) begin
                            if (c < "8") begin
                                add_en   = 1'b1;
                                add_base = 2'd0;
                            end else begin
                                mode_next = cstl_pkg::M_ODEAD;
                            end
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                cstl_pkg::M_HEX: begin
                    if (hv[4]) begin
                        cnt_next  = cnt_inc;
                        add_en    = 1'b1;
                        add_base  = 2'd2;
                        add_digit = hv[3:0];
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            if (add_en) begin
                acc_next = acc_add;
                sat_next = sat_add;
            end

            if (do_fresh) begin
                mode_next = cstl_pkg::M_IDLE;
                if (!cstl_pkg::is_space(c)) begin
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    tso_next = off_reg;
                    cnt_next = 16'd1;
                    acc_next = '0;
                    sat_next = 1'b0;
                    if (cstl_pkg::is_digit(c)) begin
                        acc_next  = 63'(c - "0");
                        mode_next = (c == "0") ? cstl_pkg::M_ZERO : cstl_pkg::M_DEC;
                    end else if (cstl_pkg::is_alpha(c) || c == "_") begin
                        kw_next   = cstl_pkg::kw_match(6'h3F, 16'd0, c);
                        mode_next = cstl_pkg::M_IDENT;
                    end else if (c == "/") begin
                        mode_next = cstl_pkg::M_SLASH;
                    end else if (cstl_pkg::is_op_lead(c)) begin
                        op_next   = c;
                        mode_next = cstl_pkg::M_OP;
                    end else if (!pu[6]) begin
                        mode_next = cstl_pkg::M_HALT;
                    end
                end
            end
        end
    end

    // tokens emitted by this byte
    always_comb begin
        a_valid = 1'b0;
        a_tok   = fl_tok;
        b_valid = 1'b0;
        b_tok   = '0;
        if (in_end) begin
            a_valid      = fl_valid && (mode_reg != cstl_pkg::M_HALT);
            b_valid      = 1'b1;
            b_tok.kind   = cstl_pkg::K_END;
            b_tok.line   = 16'(line_reg);
            b_tok.column = 16'(col_reg);
            b_tok.offset = 32'(off_reg);
        end else if (mode_reg == cstl_pkg::M_OP && pk[6]) begin
            b_valid      = 1'b1;
            b_tok        = fl_tok;
            b_tok.kind   = pk[5:0];
            b_tok.length = 16'd2;
        end else if (do_fresh) begin
            a_valid      = fl_valid;
            b_tok.line   = 16'(line_reg);
            b_tok.column = 16'(col_reg);
            b_tok.offset = 32'(off_reg);
            b_tok.length = 16'd1;
            if (!cstl_pkg::is_space(c) && !cstl_pkg::is_digit(c) && !cstl_pkg::is_alpha(c) &&
                c != "_" && c != "/" && !cstl_pkg::is_op_lead(c)) begin
                b_valid    = 1'b1;
                b_tok.kind = pu[6] ? pu[5:0] : cstl_pkg::K_ERR;
            end
        end
    end

    always_comb begin
        push_data      = '0;
        push_data.two  = a_valid && b_valid;
        push_data.tok0 = a_valid ? a_tok : b_tok;
        push_data.tok1 = b_tok;
        push_data.tok0.last = !(a_valid && b_valid);
        push_data.tok1.last = 1'b1;
        push = in_fire && (a_valid || b_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cstl_pkg::M_IDLE;
            kw_reg   <= '0;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
            op_reg   <= '0;
            line_reg <= LINE_WIDTH'(1);
            col_reg  <= COLUMN_WIDTH'(1);
            off_reg  <= '0;
            tsl_reg  <= LINE_WIDTH'(1);
            tsc_reg  <= COLUMN_WIDTH'(1);
            tso_reg  <= '0;
            cnt_reg  <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            kw_reg   <= kw_next;
            acc_reg  <= acc_next;
            sat_reg  <= sat_next;
            op_reg   <= op_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            tso_reg  <= tso_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/cstl_queue.sv =====
`include "c_subset_token_lexer_unit_assert.svh"

module cstl_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cstl_pkg::step_t   push_data,
    input  logic              pop,
    output cstl_pkg::step_t   head,
    output cstl_pkg::q_stat_t stat
);

    localparam int PW = $clog2(cstl_pkg::QDEPTH);

    cstl_pkg::step_t entry_reg [cstl_pkg::QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (PW+1)'(cstl_pkg::QDEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CSTL_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && stat.full && !pop)
    `CSTL_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && stat.empty)
    `CSTL_ASSERT_NEXT(a_fill, aclk, aresetn, push && !pop,
                      count_reg == $past(count_reg) + (PW+1)'(1))
    `CSTL_ASSERT_NEXT(a_drain, aclk, aresetn, pop && !push,
                      count_reg == $past(count_reg) - (PW+1)'(1))

endmodule

// ===== hw/rtl/cstl_back.sv =====
module cstl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  cstl_pkg::step_t   head,
    input  cstl_pkg::q_stat_t stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output cstl_pkg::tok_t    out_tok
);

    logic           valid_reg, valid_next;
    logic           sub_reg, sub_next;
    cstl_pkg::tok_t tok_reg;
    logic           load;

    assign load      = !stat.empty && (!valid_reg || out_ready);
    assign pop       = load && (!head.two || sub_reg);
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_comb begin
        sub_next   = load ? (head.two && !sub_reg) : sub_reg;
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= sub_reg ? head.tok1 : head.tok0;
        end
    end

endmodule

// ===== tb/c_subset_token_lexer_unit_tb.sv =====
module c_subset_token_lexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  kind;
        logic [62:0] value;
        logic [15:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic        last;
    } token_t;

    class lexer_scoreboard;
        token_t           tokens_due[$];
        token_t           step_toks[$];
        int               errors;
        int               tokens_seen;
        int               bytes_in;
        int               ends_in;
        cstl_pkg::mode_t  mode;
        logic [5:0]       kw_alive;
        logic [63:0]      acc;
        bit               sat;
        logic [7:0]       pend_op;
        logic [15:0]      cur_line, cur_col, tok_line, tok_col, tok_len;
        logic [31:0]      cur_off, tok_off;
        string            kw_text[6] = '{"int", "if", "else", "while", "for", "return"};

        function new();
            errors = 0;
            tokens_seen = 0;
            bytes_in = 0;
            ends_in = 0;
            clear();
        endfunction

        function void clear();
            mode = cstl_pkg::M_IDLE;
            kw_alive = '0;
            acc = '0;
            sat = 0;
            pend_op = '0;
            cur_line = 1;
            cur_col = 1;
            cur_off = 0;
            tok_line = 1;
            tok_col = 1;
            tok_off = 0;
            tok_len = 0;
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void add_tok(logic [5:0] k, logic [62:0] v, logic [15:0] ln,
                              logic [15:0] col, logic [31:0] off, logic [15:0] len);
            token_t t;
            t.kind = k;
            t.value = v;
            t.line = ln;
            t.column = col;
            t.offset = off;
            t.length = len;
            t.last = 0;
            step_toks = {step_toks, t};
        endfunction

        function void held_tok(logic [5:0] k, logic [62:0] v, logic [15:0] len);
            add_tok(k, v, tok_line, tok_col, tok_off, len);
        endfunction

        function void add_digit(logic [63:0] base, logic [63:0] d);
            logic [63:0] vmax;
            vmax = {1'b0, cstl_pkg::VMAX};
            if (sat) return;
            if (acc > (vmax - d) / base) begin
                sat = 1;
                acc = vmax;
            end else begin
                acc = acc * base + d;
            end
        endfunction

        function void narrow_kw(logic [7:0] c);
            logic [7:0] ch;
            for (int k = 0; k < 6; k++) begin
                ch = (tok_len < kw_text[k].len()) ? kw_text[k][tok_len] : 8'd0;
                if (tok_len >= 8 || ch != c) kw_alive[k] = 1'b0;
            end
        endfunction

        function void bump_len();
            if (tok_len != 16'hFFFF) tok_len++;
        endfunction

        function logic [5:0] lone_op(logic [7:0] p);
            case (p)
                "-": return cstl_pkg::K_MINUS;
                "&": return cstl_pkg::K_AMP;
                "|": return cstl_pkg::K_PIPE;
                "<": return cstl_pkg::K_LT;
                ">": return cstl_pkg::K_GT;
                "=": return cstl_pkg::K_ASSIGN;
                default: return cstl_pkg::K_NOT;
            endcase
        endfunction

        function int paired_op(logic [7:0] p, logic [7:0] c);
            case (p)
                "-": if (c == ">") return cstl_pkg::K_ARROW;
                "&": if (c == "&") return cstl_pkg::K_LAND;
                "|": if (c == "|") return cstl_pkg::K_LOR;
                "<": if (c == "<") return cstl_pkg::K_SHL;
                     else if (c == "=") return cstl_pkg::K_LE;
                ">": if (c == ">") return cstl_pkg::K_SHR;
                     else if (c == "=") return cstl_pkg::K_GE;
                "=": if (c == "=") return cstl_pkg::K_EQ;
                "!": if (c == "=") return cstl_pkg::K_NE;
                default: ;
            endcase
            return -1;
        endfunction

        function void drain_held();
            logic [5:0] k;
            case (mode)
                cstl_pkg::M_IDENT: begin
                    k = cstl_pkg::K_IDENT;
                    for (int i = 0; i < 6; i++)
                        if (kw_alive[i] && kw_text[i].len() == tok_len)
                            k = cstl_pkg::K_KW + 6'(i);
                    held_tok(k, '0, tok_len);
                end
                cstl_pkg::M_ZERO, cstl_pkg::M_DEC, cstl_pkg::M_OCT, cstl_pkg::M_ODEAD,
                cstl_pkg::M_HEX:
                    held_tok(cstl_pkg::K_INT, sat ? cstl_pkg::VMAX : acc[62:0], tok_len);
                cstl_pkg::M_OP:    held_tok(lone_op(pend_op), '0, 1);
                cstl_pkg::M_SLASH: held_tok(cstl_pkg::K_SLASH, '0, 1);
                default: ;
            endcase
            mode = cstl_pkg::M_IDLE;
        endfunction

        function void start_tok(logic [7:0] c);
            logic [5:0] k;
            mode = cstl_pkg::M_IDLE;
            if (c == " " || (c >= 9 && c <= 13)) return;
            tok_line = cur_line;
            tok_col = cur_col;
            tok_off = cur_off;
            tok_len = 1;
            acc = 0;
            sat = 0;
            if (digit(c)) begin
                acc = 64'(c - "0");
                mode = (c == "0") ? cstl_pkg::M_ZERO : cstl_pkg::M_DEC;
                return;
            end
            if (alpha(c) || c == "_") begin
                kw_alive = 6'h3F;
                tok_len = 0;
                narrow_kw(c);
                tok_len = 1;
                mode = cstl_pkg::M_IDENT;
                return;
            end
            case (c)
                "/": begin
                    mode = cstl_pkg::M_SLASH;
                    return;
                end
                "-", "&", "|", "<", ">", "=", "!": begin
                    pend_op = c;
                    mode = cstl_pkg::M_OP;
                    return;
                end
                "+": k = cstl_pkg::K_PLUS;
                "*": k = cstl_pkg::K_STAR;
                "^": k = cstl_pkg::K_CARET;
                "~": k = cstl_pkg::K_TILDE;
                "(": k = cstl_pkg::K_LPAREN;
                ")": k = cstl_pkg::K_RPAREN;
                "{": k = cstl_pkg::K_LBRACE;
                "}": k = cstl_pkg::K_RBRACE;
                "[": k = cstl_pkg::K_LBRACK;
                "]": k = cstl_pkg::K_RBRACK;
                ";": k = cstl_pkg::K_SEMI;
                ",": k = cstl_pkg::K_COMMA;
                default: begin
                    held_tok(cstl_pkg::K_ERR, '0, 1);
                    mode = cstl_pkg::M_HALT;
                    return;
                end
            endcase
            held_tok(k, '0, 1);
        endfunction

        function void boundary(logic [7:0] c);
            drain_held();
            start_tok(c);
        endfunction

        function void note_input(logic [7:0] c, logic eoi);
            int pk;
            logic [4:0] hv;
            step_toks.delete();
            if (eoi) begin
                ends_in++;
                if (mode != cstl_pkg::M_HALT) drain_held();
                add_tok(cstl_pkg::K_END, '0, cur_line, cur_col, cur_off, 0);
                clear();
            end else begin
                bytes_in++;
                case (mode)
                    cstl_pkg::M_HALT: ;
                    cstl_pkg::M_LINE: if (c == "\n") mode = cstl_pkg::M_IDLE;
                    cstl_pkg::M_BLOCK: if (c == "*") mode = cstl_pkg::M_BSTAR;
                    cstl_pkg::M_BSTAR:
                        mode = (c == "/") ? cstl_pkg::M_IDLE :
                               (c == "*" ? cstl_pkg::M_BSTAR : cstl_pkg::M_BLOCK);
                    cstl_pkg::M_SLASH: begin
                        if (c == "/") mode = cstl_pkg::M_LINE;
                        else if (c == "*") mode = cstl_pkg::M_BLOCK;
                        else boundary(c);
                    end
                    cstl_pkg::M_OP: begin
                        pk = paired_op(pend_op, c);
                        if (pk >= 0) begin
                            held_tok(6'(pk), '0, 2);
                            mode = cstl_pkg::M_IDLE;
                        end else boundary(c);
                    end
                    cstl_pkg::M_IDENT: begin
                        if (alpha(c) || digit(c) || c == "_") begin
                            narrow_kw(c);
                            bump_len();
                        end else boundary(c);
                    end
                    cstl_pkg::M_ZERO: begin
                        if (c == "x" || c == "X") begin
                            bump_len();
                            mode = cstl_pkg::M_HEX;
                        end else if (digit(c)) begin
                            bump_len();
                            if (c < "8") begin
                                add_digit(8, 64'(c - "0"));
                                mode = cstl_pkg::M_OCT;
                            end else mode = cstl_pkg::M_ODEAD;
                        end else boundary(c);
                    end
                    cstl_pkg::M_DEC, cstl_pkg::M_OCT, cstl_pkg::M_ODEAD: begin
                        if (digit(c)) begin
                            bump_len();
                            if (mode == cstl_pkg::M_DEC) add_digit(10, 64'(c - "0"));
                            else if (mode == cstl_pkg::M_OCT) begin
                                if (c < "8") add_digit(8, 64'(c - "0"));
                                else mode = cstl_pkg::M_ODEAD;
                            end
                        end else boundary(c);
                    end
                    cstl_pkg::M_HEX: begin
                        hv = 5'd0;
                        if (digit(c)) hv = {1'b1, 4'(c - "0")};
                        else if (c >= "a" && c <= "f") hv = {1'b1, 4'(c - "a" + 10)};
                        else if (c >= "A" && c <= "F") hv = {1'b1, 4'(c - "A" + 10)};
                        if (hv[4]) begin
                            bump_len();
                            add_digit(16, 64'(hv[3:0]));
                        end else boundary(c);
                    end
                    default: start_tok(c);
                endcase
                if (c == "\n") begin
                    if (cur_line != 16'hFFFF) cur_line++;
                    cur_col = 1;
                end else if (cur_col != 16'hFFFF) cur_col++;
                if (cur_off != 32'hFFFF_FFFF) cur_off++;
            end
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
            foreach (step_toks[i]) tokens_due = {tokens_due, step_toks[i]};
        endfunction

        function void check_token(token_t got);
            token_t w;
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token kind %0d", $time, got.kind);
                errors++;
                return;
            end
            w = tokens_due.pop_front();
            if (got.kind != w.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, w.kind, got.kind);
                errors++;
            end
            if (got.value != w.value) begin
                $display("%0t: value exp %0d got %0d", $time, w.value, got.value);
                errors++;
            end
            if (got.line != w.line) begin
                $display("%0t: line exp %0d got %0d", $time, w.line, got.line);
                errors++;
            end
            if (got.column != w.column) begin
                $display("%0t: column exp %0d got %0d", $time, w.column, got.column);
                errors++;
            end
            if (got.offset != w.offset) begin
                $display("%0t: offset exp %0d got %0d", $time, w.offset, got.offset);
                errors++;
            end
            if (got.length != w.length) begin
                $display("%0t: length exp %0d got %0d", $time, w.length, got.length);
                errors++;
            end
            if (got.last != w.last) begin
                $display("%0t: last exp %0b got %0b", $time, w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [5:0]   m_tuser;
    logic         m_tlast;

    lexer_scoreboard lex_sb = new();
    bit calm = 0;
    int stall_cycles = 0;

    always #4 aclk = ~aclk;

    c_subset_token_lexer_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always @(negedge aclk) begin
        m_tready <= aresetn && (calm || $urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        token_t t;
        if (aresetn && m_tvalid && m_tready) begin
            t.value = m_tdata[62:0];
            t.line = m_tdata[78:63];
            t.column = m_tdata[94:79];
            t.offset = m_tdata[126:95];
            t.length = m_tdata[142:127];
            t.kind = m_tuser;
            t.last = m_tlast;
            lex_sb.check_token(t);
        end
        if (aresetn && !((m_tvalid && m_tready) || (s_tvalid && s_tready)))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles > 3000) begin
            $display("c_subset_token_lexer_unit regression: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eoi);
        while (!calm && $urandom_range(99) < 35) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tdata = c;
        s_tlast = eoi;
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        lex_sb.note_input(c, eoi);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
    endtask

    task automatic wait_drained();
        while (lex_sb.tokens_due.size() != 0) @(posedge aclk);
    endtask

    function automatic string random_word();
        string s;
        string hexd;
        int n;
        hexd = "0123456789abcdefABCDEF";
        s = "";
        case ($urandom_range(15))
            0: begin
                string kws[6] = '{"int", "if", "else", "while", "for", "return"};
                s = kws[$urandom_range(5)];
                if ($urandom_range(3) == 0) s = s.substr(0, s.len() - 2);
                else if ($urandom_range(3) == 0) s = {s, "_"};
            end
            1, 2: begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(3))
                        0: s = {s, string'(8'("A" + $urandom_range(25)))};
                        1: s = {s, string'(8'("a" + $urandom_range(25)))};
                        2: s = {s, string'(8'("0" + $urandom_range(9)))};
                        default: s = {s, "_"};
                    endcase
                if (s[0] >= "0" && s[0] <= "9") s = {"z", s};
            end
            3: begin
                n = ($urandom_range(4) == 0) ? $urandom_range(24, 18) : $urandom_range(5, 1);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
            end
            4: begin
                s = ($urandom_range(1)) ? "0x" : "0X";
                n = ($urandom_range(4) == 0) ? $urandom_range(20, 15) : $urandom_range(4);
                for (int i = 0; i < n; i++) s = {s, string'(hexd[$urandom_range(21)])};
            end
            5: begin
                s = "0";
                n = ($urandom_range(4) == 0) ? $urandom_range(25, 20) : $urandom_range(4);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
            end
            6, 7: begin
                string ops[13] = '{"->", "&&", "||", "<<", "<=", ">>", ">=", "==", "!=",
                                   "-", "&", "<", "!"};
                s = ops[$urandom_range(12)];
            end
            8: begin
                string pc = "+*^~(){}[];,|>=/";
                s = string'(pc[$urandom_range(15)]);
            end
            9: s = ($urandom_range(1)) ? "// note\n" : "/* a * b **/";
            10: s = ($urandom_range(1)) ? "\n" : "\t";
            11: s = string'(8'($urandom_range(255)));
            default: s = " ";
        endcase
        return s;
    endfunction

    initial begin
        int frags;
        int paused;
        paused = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        send_text("int if2 0x1F 019 0xffffffffffffffffff ->/*/");
        send_byte(8'hA5, 1);
        send_text("a=b!c// x");
        send_byte(8'h5A, 1);
        send_text("@1 q");
        send_byte(8'hFF, 1);

        while (lex_sb.bytes_in + lex_sb.ends_in < 720) begin
            calm = (lex_sb.bytes_in > 300 && lex_sb.bytes_in < 450);
            if (!paused && lex_sb.bytes_in > 500) begin
                paused = 1;
                wait_drained();
                @(negedge aclk);
            end
            frags = $urandom_range(40, 3);
            for (int i = 0; i < frags; i++) begin
                send_text(random_word());
                if ($urandom_range(2) == 0) send_byte(" ", 0);
            end
            send_byte(8'($urandom_range(255)), 1);
        end
        calm = 0;

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Lexed %0d bytes over %0d end markers into %0d tokens: keywords, names,",
                 lex_sb.bytes_in, lex_sb.ends_in, lex_sb.tokens_seen);
        $display("number bases with saturation, operators, comments, bad bytes, stalls.");
        if (lex_sb.errors == 0 && lex_sb.tokens_due.size() == 0) begin
            $display("c_subset_token_lexer_unit regression: pass");
        end else begin
            $display("c_subset_token_lexer_unit regression: fail");
        end
        $finish;
    end
endmodule
